/* rtl/bcu_pkg.sv */
`timescale 1ns / 1ps

package bcu_pkg;

  localparam int unsigned OPERAND_BITS = 8;
  localparam int unsigned RESULT_BITS  = 64;
  localparam int unsigned PROD_BITS    = RESULT_BITS + OPERAND_BITS;
  localparam int unsigned CNT_BITS     = $clog2(RESULT_BITS);

  typedef enum logic [1:0] {
    CASE_ONE,
    CASE_ZERO,
    CASE_PROD,
    CASE_BINOM
  } bcu_case_e;

  typedef struct packed {
    logic start;
    logic mul_step;
    logic den_init;
    logic div_init;
    logic div_step;
    logic out_load;
  } bcu_cmd_t;

  typedef struct packed {
    bcu_case_e in_case;
    logic      mul_ovf;
    logic      mul_last;
    logic      div_last;
  } bcu_sts_t;

endpackage

/* rtl/bcu_ctrl.sv */
`timescale 1ns / 1ps

module bcu_ctrl import bcu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  bcu_sts_t sts_i,
  output bcu_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULP = 3'd1;
  localparam logic [2:0] S_MULN = 3'd2;
  localparam logic [2:0] S_DENI = 3'd3;
  localparam logic [2:0] S_MULD = 3'd4;
  localparam logic [2:0] S_DIVI = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (sts_i.in_case)
            CASE_PROD:  state_d = S_MULP;
            CASE_BINOM: state_d = S_MULN;
            default:    state_d = S_FIN;
          endcase
        end
      end
      S_MULP: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_ovf || sts_i.mul_last) state_d = S_FIN;
      end
      S_MULN: begin
        cmd_o.mul_step = 1'b1;
        priority if (sts_i.mul_ovf) state_d = S_FIN;
        else if (sts_i.mul_last)    state_d = S_DENI;
      end
      S_DENI: begin
        cmd_o.den_init = 1'b1;
        state_d        = S_MULD;
      end
      S_MULD: begin
        cmd_o.mul_step = 1'b1;
        priority if (sts_i.mul_ovf) state_d = S_FIN;
        else if (sts_i.mul_last)    state_d = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i)       out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/bcu_datapath.sv */
`timescale 1ns / 1ps

module bcu_datapath import bcu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    func_i,
  input  logic [OPERAND_BITS-1:0] first_operand_i,
  input  logic [OPERAND_BITS-1:0] second_operand_i,
  input  bcu_cmd_t                cmd_i,
  output bcu_sts_t                sts_o,
  output logic [RESULT_BITS-1:0]  value_o,
  output logic                    overflow_o
);

  logic [RESULT_BITS-1:0]  acc_q, acc_d;
  logic [RESULT_BITS-1:0]  num_q, num_d;
  logic [RESULT_BITS-1:0]  rem_q, rem_d;
  logic [OPERAND_BITS-1:0] i_q, i_d;
  logic [OPERAND_BITS-1:0] hi_q, hi_d;
  logic [OPERAND_BITS-1:0] k_q, k_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic                    quo_sel_q, quo_sel_d;
  logic [RESULT_BITS-1:0]  value_q, value_d;
  logic                    overflow_q, overflow_d;

  logic [PROD_BITS-1:0]    prod;
  logic [RESULT_BITS:0]    shifted;
  logic [RESULT_BITS:0]    diff;
  bcu_case_e               in_case;

  assign prod    = PROD_BITS'(acc_q) * PROD_BITS'(i_q);
  assign shifted = {rem_q, num_q[RESULT_BITS-1]};
  assign diff    = shifted - {1'b0, acc_q};

  always_comb begin
    priority if (!func_i) begin
      in_case = (second_operand_i > first_operand_i) ? CASE_ONE : CASE_PROD;
    end else if (second_operand_i > first_operand_i) begin
      in_case = CASE_ZERO;
    end else if (second_operand_i == '0) begin
      in_case = CASE_ONE;
    end else begin
      in_case = CASE_BINOM;
    end
  end

  assign sts_o.in_case  = in_case;
  assign sts_o.mul_ovf  = |prod[PROD_BITS-1:RESULT_BITS];
  assign sts_o.mul_last = (i_q == hi_q);
  assign sts_o.div_last = (cnt_q == '0);

  always_comb begin
    acc_d      = acc_q;
    num_d      = num_q;
    rem_d      = rem_q;
    i_d        = i_q;
    hi_d       = hi_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    quo_sel_d  = quo_sel_q;
    value_d    = value_q;
    overflow_d = overflow_q;
    if (cmd_i.start) begin
      acc_d     = (in_case == CASE_ZERO) ? '0 : RESULT_BITS'(1);
      i_d       = func_i ? (first_operand_i - second_operand_i + OPERAND_BITS'(1))
                         : second_operand_i;
      hi_d      = first_operand_i;
      k_d       = second_operand_i;
      ovf_d     = 1'b0;
      quo_sel_d = 1'b0;
    end
    if (cmd_i.mul_step) begin
      if (sts_o.mul_ovf) begin
        acc_d = '0;
        ovf_d = 1'b1;
      end else begin
        acc_d = prod[RESULT_BITS-1:0];
        i_d   = i_q + OPERAND_BITS'(1);
      end
    end
    if (cmd_i.den_init) begin
      num_d = acc_q;
      acc_d = RESULT_BITS'(1);
      i_d   = OPERAND_BITS'(1);
      hi_d  = k_q;
    end
    if (cmd_i.div_init) begin
      rem_d     = '0;
      cnt_d     = CNT_BITS'(RESULT_BITS - 1);
      quo_sel_d = 1'b1;
    end
    if (cmd_i.div_step) begin
      if (!diff[RESULT_BITS]) begin
        rem_d = diff[RESULT_BITS-1:0];
        num_d = {num_q[RESULT_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted[RESULT_BITS-1:0];
        num_d = {num_q[RESULT_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
    end
    if (cmd_i.out_load) begin
      value_d    = quo_sel_q ? num_q : acc_q;
      overflow_d = ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    i_q        <= i_d;
    hi_q       <= hi_d;
    k_q        <= k_d;
    cnt_q      <= cnt_d;
    ovf_q      <= ovf_d;
    quo_sel_q  <= quo_sel_d;
    value_q    <= value_d;
    overflow_q <= overflow_d;
  end

  assign value_o    = value_q;
  assign overflow_o = overflow_q;

endmodule

/* rtl/binomial_coefficient_unit.sv */
`timescale 1ns / 1ps
// channel  handshake            word
// in       in_valid_i/in_stall_o  func_i, first_operand_i, second_operand_i
// out      out_valid_o/out_stall_i value_o, overflow_o
//
// One word at a time; products of operands 0..255 run on the 64x8 multiplier,
// and C(n,k) then also runs the 64-bit restoring divider. Trivial cases skip
// the multiplier and the divider.
// Reset clears the controller and output valid; the datapath is not reset.
// A result held under out_stall_i parks the controller in its final state
// while the input stays stalled.

module binomial_coefficient_unit import bcu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    func_i,
  input  logic [OPERAND_BITS-1:0] first_operand_i,
  input  logic [OPERAND_BITS-1:0] second_operand_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [RESULT_BITS-1:0]  value_o,
  output logic                    overflow_o
);

  bcu_cmd_t cmd;
  bcu_sts_t sts;

  bcu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcu_datapath u_datapath (
    .clk_i           (clk_i),
    .func_i          (func_i),
    .first_operand_i (first_operand_i),
    .second_operand_i(second_operand_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .value_o         (value_o),
    .overflow_o      (overflow_o)
  );

`ifndef SYNTHESIS
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (value_o == '0))
    else $error("overflow with nonzero value");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a word in flight");
`endif

endmodule
